// ----- design/sfs_pkg.sv -----
// Shared types and constants of the stuffed frame sender.
package sfs_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_MASK  = 8'h20;

   localparam logic [7:0] LOCAL_ADDR_RESET = 8'h03;
   localparam logic [7:0] PEER_ADDR_RESET  = 8'h01;
   localparam logic [7:0] ACK_BASE_RESET   = 8'h07;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_ADDR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEER_ADDR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_BASE   = 2'd2;

   // Acknowledgement recognizer states
   typedef enum logic [3:0] {
      RX_IDLE = 4'b0001,
      RX_FLAG = 4'b0010,
      RX_ADDR = 4'b0100,
      RX_CTRL = 4'b1000
   } rx_state_type;

   // Output sequencer steps
   typedef enum logic [10:0] {
      ST_START = 11'b00000000001,
      ST_HFLAG = 11'b00000000010,
      ST_HADDR = 11'b00000000100,
      ST_HCTRL = 11'b00000001000,
      ST_HCHK  = 11'b00000010000,
      ST_DATA  = 11'b00000100000,
      ST_DESC  = 11'b00001000000,
      ST_CHK   = 11'b00010000000,
      ST_CESC  = 11'b00100000000,
      ST_CLOSE = 11'b01000000000,
      ST_RX    = 11'b10000000000
   } step_type;

   // One classified item, as handed from the front to the back
   typedef struct packed {
      logic       rx;
      logic [7:0] data;
      logic       first;
      logic       last;
      logic [7:0] addr;
      logic       seq;
      logic [7:0] check;
      logic       ack;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } qhead_type;

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

endpackage

// ----- design/sfs_if.sv -----
// Request and response channel interfaces.
interface sfs_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       last_byte;
   logic       seq_bit;

   modport source (output valid, action, data_byte, first_byte, last_byte, seq_bit,
                   input ready);
   modport sink   (input valid, action, data_byte, first_byte, last_byte, seq_bit,
                   output ready);
endinterface

interface sfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_valid;
   logic       ack_seen;
   logic       last_of_run;

   modport source (output valid, tx_byte, tx_valid, ack_seen, last_of_run, input ready);
   modport sink   (input valid, tx_byte, tx_valid, ack_seen, last_of_run, output ready);
endinterface

// ----- design/sfs_front.sv -----
// Front end: config registers, check/sequence state and ack recognizer.
module sfs_front (
   input  logic                            clock,
   input  logic                            reset,
   sfs_req_if.sink                         req_chan,
   input  logic                            csr_we,
   input  logic [sfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                      csr_wdata,
   input  logic                            q_full,
   output logic                            q_push,
   output sfs_pkg::job_type                q_job
);
   import sfs_pkg::*;

   logic [7:0]   local_addr_ff, local_addr_in;
   logic [7:0]   peer_addr_ff, peer_addr_in;
   logic [7:0]   ack_base_ff, ack_base_in;
   logic [7:0]   check_ff, check_in;
   logic         seq_ff, seq_in;
   rx_state_type rx_state_ff, rx_state_in;

   logic         accept;
   logic [7:0]   ack_ctrl;
   logic         ack;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign q_push         = accept;
   assign ack_ctrl       = ack_base_ff ^ {7'b0, seq_ff};

   always_comb begin
      local_addr_in = local_addr_ff;
      peer_addr_in  = peer_addr_ff;
      ack_base_in   = ack_base_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LOCAL_ADDR: local_addr_in = csr_wdata;
            CSR_PEER_ADDR:  peer_addr_in  = csr_wdata;
            CSR_ACK_BASE:   ack_base_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      check_in    = check_ff;
      seq_in      = seq_ff;
      rx_state_in = rx_state_ff;
      ack         = 1'b0;
      if (accept) begin
         if (!req_chan.action) begin
            if (req_chan.first_byte) begin
               check_in    = req_chan.data_byte;
               seq_in      = req_chan.seq_bit;
               rx_state_in = RX_IDLE;
            end else begin
               check_in = check_ff ^ req_chan.data_byte;
            end
         end else begin
            case (rx_state_ff)
               RX_IDLE: begin
                  if (req_chan.data_byte == FLAG_BYTE) rx_state_in = RX_FLAG;
               end
               RX_FLAG: begin
                  if (req_chan.data_byte == peer_addr_ff)   rx_state_in = RX_ADDR;
                  else if (req_chan.data_byte == FLAG_BYTE) rx_state_in = RX_FLAG;
                  else                                      rx_state_in = RX_IDLE;
               end
               RX_ADDR: begin
                  if (req_chan.data_byte == ack_ctrl)       rx_state_in = RX_CTRL;
                  else if (req_chan.data_byte == FLAG_BYTE) rx_state_in = RX_FLAG;
                  else                                      rx_state_in = RX_IDLE;
               end
               default: begin
                  if (req_chan.data_byte == (peer_addr_ff ^ ack_ctrl)) begin
                     ack         = 1'b1;
                     rx_state_in = RX_IDLE;
                  end else if (req_chan.data_byte == FLAG_BYTE) begin
                     rx_state_in = RX_FLAG;
                  end else begin
                     rx_state_in = RX_IDLE;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      q_job.rx    = req_chan.action;
      q_job.data  = req_chan.data_byte;
      q_job.first = req_chan.first_byte;
      q_job.last  = req_chan.last_byte;
      q_job.addr  = local_addr_ff;
      q_job.seq   = req_chan.seq_bit;
      q_job.check = check_in;
      q_job.ack   = ack;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= LOCAL_ADDR_RESET;
         peer_addr_ff  <= PEER_ADDR_RESET;
         ack_base_ff   <= ACK_BASE_RESET;
         check_ff      <= 8'h00;
         seq_ff        <= 1'b0;
         rx_state_ff   <= RX_IDLE;
      end else begin
         local_addr_ff <= local_addr_in;
         peer_addr_ff  <= peer_addr_in;
         ack_base_ff   <= ack_base_in;
         check_ff      <= check_in;
         seq_ff        <= seq_in;
         rx_state_ff   <= rx_state_in;
      end
   end

endmodule

// ----- design/sfs_queue.sv -----
// Small register FIFO of classified jobs between front and back.
module sfs_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sfs_pkg::job_type    push_job,
   input  logic                pop,
   output logic                full,
   output sfs_pkg::qhead_type  head
);
   import sfs_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/sfs_back.sv -----
// Back end: expands the job at the queue head into line bytes, one per cycle unless the response register is stalled.
module sfs_back (
   input  logic                clock,
   input  logic                reset,
   input  sfs_pkg::qhead_type  head,
   output logic                pop,
   sfs_rsp_if.source           rsp_chan
);
   import sfs_pkg::*;

   step_type   step_ff, step_in;
   step_type   cur_step, next_step;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] tx_byte_ff;
   logic       tx_valid_ff, ack_seen_ff, last_of_run_ff;

   logic       emit, done;
   logic [7:0] out_byte;
   logic       out_txv;
   logic       out_ack;
   logic [7:0] ctrl;

   assign ctrl = {7'b0, head.job.seq};
   assign emit = head.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign pop  = emit && done;

   // START stands for "first step of whatever job sits at the head"
   always_comb begin
      if (step_ff == ST_START) begin
         if (head.job.rx)         cur_step = ST_RX;
         else if (head.job.first) cur_step = ST_HFLAG;
         else                     cur_step = ST_DATA;
      end else begin
         cur_step = step_ff;
      end
   end

   always_comb begin
      out_byte  = 8'h00;
      out_txv   = 1'b1;
      out_ack   = 1'b0;
      done      = 1'b0;
      next_step = ST_START;
      case (cur_step)
         ST_HFLAG: begin
            out_byte  = FLAG_BYTE;
            next_step = ST_HADDR;
         end
         ST_HADDR: begin
            out_byte  = head.job.addr;
            next_step = ST_HCTRL;
         end
         ST_HCTRL: begin
            out_byte  = ctrl;
            next_step = ST_HCHK;
         end
         ST_HCHK: begin
            out_byte  = head.job.addr ^ ctrl;
            next_step = ST_DATA;
         end
         ST_DATA: begin
            if (needs_escape(head.job.data)) begin
               out_byte  = ESC_BYTE;
               next_step = ST_DESC;
            end else begin
               out_byte  = head.job.data;
               next_step = head.job.last ? ST_CHK : ST_START;
               done      = !head.job.last;
            end
         end
         ST_DESC: begin
            out_byte  = head.job.data ^ ESC_MASK;
            next_step = head.job.last ? ST_CHK : ST_START;
            done      = !head.job.last;
         end
         ST_CHK: begin
            if (needs_escape(head.job.check)) begin
               out_byte  = ESC_BYTE;
               next_step = ST_CESC;
            end else begin
               out_byte  = head.job.check;
               next_step = ST_CLOSE;
            end
         end
         ST_CESC: begin
            out_byte  = head.job.check ^ ESC_MASK;
            next_step = ST_CLOSE;
         end
         ST_CLOSE: begin
            out_byte = FLAG_BYTE;
            done     = 1'b1;
         end
         ST_RX: begin
            out_txv = 1'b0;
            out_ack = head.job.ack;
            done    = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (emit) begin
         step_in = done ? ST_START : next_step;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         tx_byte_ff     <= out_byte;
         tx_valid_ff    <= out_txv;
         ack_seen_ff    <= out_ack;
         last_of_run_ff <= done;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tx_byte     = tx_byte_ff;
   assign rsp_chan.tx_valid    = tx_valid_ff;
   assign rsp_chan.ack_seen    = ack_seen_ff;
   assign rsp_chan.last_of_run = last_of_run_ff;

endmodule

// ----- design/stuffed_frame_sender_with_ack_core.sv -----
// Stuffed frame sender with acknowledgement recognizer: top level.
// Every accepted transaction yields one or more response transactions, one per clock
// cycle unless rsp_chan.ready stalls: a received line byte gives one, a payload byte
// gives one or two (stuffed), plus four header bytes when it opens a frame and two
// to three more (check and closing flag) when it ends one, nine at most. The output
// sequencer that emits these bytes sets the throughput; the front end takes one
// request per cycle while its job queue (QUEUE_DEPTH entries) has room, and a
// response register after the job queue decouples the sequencer from rsp_chan.ready.
// Config writes through csr_* take effect on the next cycle and are meant to
// happen only while the block is idle; index 3 is ignored.
module stuffed_frame_sender_with_ack_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   sfs_req_if.sink                        req_chan,
   sfs_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [sfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                     csr_wdata
);
   import sfs_pkg::*;

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   job_type   q_job;
   qhead_type q_head;

   sfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (q_job)
   );

   sfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .full     (q_full),
      .head     (q_head)
   );

   sfs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- design/sfs_checker.sv -----
// Port-level checks on the stuffed frame sender, bound to the top level.
module sfs_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_tx_valid,
   input logic rsp_ack_seen,
   input logic rsp_last_of_run,
   input logic [7:0] rsp_tx_byte
);

   // Reset leaves no response pending
   a_reset_idle: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A received-byte response is a single empty byte
   a_rx_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_tx_valid) |-> (rsp_last_of_run && rsp_tx_byte == 8'h00))
      else $error("received-byte response malformed");

   // Acknowledgement only reported on received-byte responses
   a_ack_no_tx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ack_seen) |-> !rsp_tx_valid)
      else $error("ack_seen on a transmit byte");

   // A stalled response stays pending
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind stuffed_frame_sender_with_ack_core sfs_checker u_sfs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_tx_valid    (rsp_chan.tx_valid),
   .rsp_ack_seen    (rsp_chan.ack_seen),
   .rsp_last_of_run (rsp_chan.last_of_run),
   .rsp_tx_byte     (rsp_chan.tx_byte)
);

// ----- verif/stuffed_frame_sender_with_ack_core_test.sv -----
`timescale 1ns / 1ps
// Self-checking test of the stuffed frame sender core: directed and random transactions.
module stuffed_frame_sender_with_ack_core_test;
   import sfs_pkg::*;

   localparam int   WATCHDOG_LIMIT = 1000;
   localparam int   DRAIN_CYCLES   = 8;
   localparam int   HOLD_CYCLES    = 120;
   localparam int   PHASE_ITEMS    = 36;
   localparam logic ACT_SEND       = 1'b0;
   localparam logic ACT_RECV       = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       ack_seen;
      logic       last_of_run;
   } line_out_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_wdata;

   sfs_req_if req_if ();
   sfs_rsp_if rsp_if ();

   stuffed_frame_sender_with_ack_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of registers and state
   logic [7:0]   cfg_local;
   logic [7:0]   cfg_peer;
   logic [7:0]   cfg_ack_base;
   logic [7:0]   check_acc;
   logic         frame_seq;
   rx_state_type rx_state;

   line_out_type expected_line_bytes[$];

   int error_count   = 0;
   int items_sent    = 0;
   int cycle_count   = 0;
   int hold_until    = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles  = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (cycle_count < hold_until) begin
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   task automatic push_line_byte(input logic [7:0] b, input logic v, input logic a);
      line_out_type r;
      r.tx_byte     = b;
      r.tx_valid    = v;
      r.ack_seen    = a;
      r.last_of_run = 1'b0;
      expected_line_bytes.push_back(r);
   endtask

   task automatic push_stuffed(input logic [7:0] b);
      if (b == FLAG_BYTE || b == ESC_BYTE) begin
         push_line_byte(ESC_BYTE, 1'b1, 1'b0);
         push_line_byte(b ^ ESC_MASK, 1'b1, 1'b0);
      end else begin
         push_line_byte(b, 1'b1, 1'b0);
      end
   endtask

   task automatic predict_line_output(input logic act, input logic [7:0] b,
                                      input logic f, input logic l, input logic s);
      logic [7:0]   ctrl;
      logic         ack;
      line_out_type tail;
      if (act == ACT_SEND) begin
         if (f) begin
            // new frame: header goes out raw, recognizer waits for a fresh ack
            ctrl      = {7'd0, s};
            frame_seq = s;
            check_acc = 8'h00;
            rx_state  = RX_IDLE;
            push_line_byte(FLAG_BYTE, 1'b1, 1'b0);
            push_line_byte(cfg_local, 1'b1, 1'b0);
            push_line_byte(ctrl, 1'b1, 1'b0);
            push_line_byte(cfg_local ^ ctrl, 1'b1, 1'b0);
         end
         check_acc = check_acc ^ b;
         push_stuffed(b);
         if (l) begin
            push_stuffed(check_acc);
            push_line_byte(FLAG_BYTE, 1'b1, 1'b0);
         end
      end else begin
         ctrl = cfg_ack_base ^ {7'd0, frame_seq};
         ack  = 1'b0;
         case (rx_state)
            RX_IDLE: begin
               if (b == FLAG_BYTE) rx_state = RX_FLAG;
            end
            RX_FLAG: begin
               if (b == cfg_peer) rx_state = RX_ADDR;
               else if (b == FLAG_BYTE) rx_state = RX_FLAG;
               else rx_state = RX_IDLE;
            end
            RX_ADDR: begin
               if (b == ctrl) rx_state = RX_CTRL;
               else if (b == FLAG_BYTE) rx_state = RX_FLAG;
               else rx_state = RX_IDLE;
            end
            default: begin
               if (b == (cfg_peer ^ ctrl)) begin
                  ack      = 1'b1;
                  rx_state = RX_IDLE;
               end else if (b == FLAG_BYTE) begin
                  rx_state = RX_FLAG;
               end else begin
                  rx_state = RX_IDLE;
               end
            end
         endcase
         push_line_byte(8'h00, 1'b0, ack);
      end
      tail = expected_line_bytes.pop_back();
      tail.last_of_run = 1'b1;
      expected_line_bytes.push_back(tail);
   endtask

   task automatic send_item(input logic act, input logic [7:0] b,
                            input logic f, input logic l, input logic s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.action     <= act;
      req_if.data_byte  <= b;
      req_if.first_byte <= f;
      req_if.last_byte  <= l;
      req_if.seq_bit    <= s;
      // results pass through the job queue and the response register, so predicting now is safe
      predict_line_output(act, b, f, l, s);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_line_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] la, input logic [7:0] pa, input logic [7:0] ab);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_LOCAL_ADDR;
      csr_wdata <= la;
      @(posedge clock);
      cfg_local = la;
      csr_index <= CSR_PEER_ADDR;
      csr_wdata <= pa;
      @(posedge clock);
      cfg_peer = pa;
      csr_index <= CSR_ACK_BASE;
      csr_wdata <= ab;
      @(posedge clock);
      cfg_ack_base = ab;
      // unused index must not disturb anything
      csr_index <= CSR_UNUSED;
      csr_wdata <= 8'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0, 1:    return FLAG_BYTE;
         2:       return ESC_BYTE;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   task automatic send_random_frame();
      int   len;
      logic s;
      logic drop_last;
      len       = ($urandom_range(7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
      s         = rand_bit();
      drop_last = ($urandom_range(9) == 0);
      for (int i = 0; i < len; i++) begin
         send_item(ACT_SEND, pick_byte(), i == 0, (i == len - 1) && !drop_last,
                   (i == 0) ? s : rand_bit());
      end
   endtask

   task automatic send_ack(input logic corrupt);
      logic [7:0] ack_bytes[4];
      logic [7:0] ctrl;
      ctrl      = cfg_ack_base ^ {7'd0, frame_seq};
      ack_bytes = '{FLAG_BYTE, cfg_peer, ctrl, cfg_peer ^ ctrl};
      if (corrupt) ack_bytes[$urandom_range(3)] = pick_byte();
      if ($urandom_range(3) == 0) send_item(ACT_RECV, FLAG_BYTE, rand_bit(), rand_bit(),
                                            rand_bit());
      foreach (ack_bytes[k]) begin
         send_item(ACT_RECV, ack_bytes[k], rand_bit(), rand_bit(), rand_bit());
      end
   endtask

   task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
      int stop_at;
      int pick;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      stop_at       = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 45) send_random_frame();
         else if (pick < 75) send_ack(1'b0);
         else if (pick < 88) send_ack(1'b1);
         else send_item(rand_bit(), pick_byte(), rand_bit(), rand_bit(), rand_bit());
      end
   endtask

   task automatic test_directed_frames();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_item(ACT_SEND, 8'h00, 1'b1, 1'b1, 1'b0);
      send_item(ACT_SEND, FLAG_BYTE, 1'b1, 1'b0, 1'b1);
      send_item(ACT_SEND, ESC_BYTE, 1'b0, 1'b0, 1'b0);
      send_item(ACT_SEND, 8'hFF, 1'b0, 1'b1, 1'b0);
      // check byte itself needs escaping
      send_item(ACT_SEND, ESC_BYTE, 1'b1, 1'b1, 1'b1);
      // payload with no open frame keeps check and sequence
      send_item(ACT_SEND, 8'h12, 1'b0, 1'b1, 1'b0);
   endtask

   task automatic test_directed_ack_recognizer();
      logic [7:0] ctrl;
      ctrl = cfg_ack_base ^ {7'd0, frame_seq};
      send_item(ACT_RECV, FLAG_BYTE, 1'b0, 1'b0, 1'b0);
      send_item(ACT_RECV, cfg_peer, 1'b1, 1'b1, 1'b1);
      send_item(ACT_RECV, ctrl, 1'b0, 1'b0, 1'b0);
      send_item(ACT_RECV, cfg_peer ^ ctrl, 1'b0, 1'b0, 1'b0);
      // closing flag of the ack is taken as a new opening flag
      send_item(ACT_RECV, FLAG_BYTE, 1'b0, 1'b0, 1'b0);
      send_item(ACT_RECV, FLAG_BYTE, 1'b0, 1'b0, 1'b0);
      send_item(ACT_RECV, cfg_peer, 1'b0, 1'b0, 1'b0);
      send_item(ACT_RECV, FLAG_BYTE, 1'b0, 1'b0, 1'b0);
      send_item(ACT_RECV, cfg_peer, 1'b0, 1'b0, 1'b0);
      send_item(ACT_RECV, ctrl, 1'b0, 1'b0, 1'b0);
      send_item(ACT_RECV, 8'h00, 1'b0, 1'b0, 1'b0);
      // a new frame in the middle of an ack throws the recognizer back to idle
      send_item(ACT_RECV, FLAG_BYTE, 1'b0, 1'b0, 1'b0);
      send_item(ACT_RECV, cfg_peer, 1'b0, 1'b0, 1'b0);
      send_item(ACT_SEND, 8'h55, 1'b1, 1'b1, 1'b0);
      send_item(ACT_RECV, cfg_ack_base, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_unstuffed_header();
      set_config(FLAG_BYTE, ESC_BYTE, 8'hFF);
      send_item(ACT_SEND, FLAG_BYTE, 1'b1, 1'b1, 1'b1);
      send_ack(1'b0);
      set_config(ESC_BYTE, 8'h00, 8'h00);
      send_item(ACT_SEND, 8'h00, 1'b1, 1'b1, 1'b0);
   endtask

   task automatic test_random_traffic();
      set_config(LOCAL_ADDR_RESET, PEER_ADDR_RESET, ACK_BASE_RESET);
      run_random_phase(PHASE_ITEMS, 0, 0);
      set_config(8'h00, 8'h00, 8'h00);
      run_random_phase(PHASE_ITEMS, 69, 0);
      set_config(8'hFF, 8'hFF, 8'hFF);
      run_random_phase(PHASE_ITEMS, 0, 69);
      set_config(8'($urandom), 8'($urandom), 8'($urandom));
      run_random_phase(PHASE_ITEMS, 18, 18);
      set_config(8'($urandom), pick_byte(), 8'($urandom));
      run_random_phase(PHASE_ITEMS, 0, 0);
   endtask

   task automatic test_backpressure();
      wait_idle();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_until    = cycle_count + HOLD_CYCLES;
      repeat (6) send_random_frame();
   endtask

   // Scoreboard: every response transaction against the oldest prediction
   always @(posedge clock) begin
      line_out_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_line_bytes.size() == 0) begin
            report_mismatch("unexpected result, tx_byte", rsp_if.tx_byte, 0);
         end else begin
            want = expected_line_bytes.pop_front();
            if (rsp_if.tx_byte !== want.tx_byte)
               report_mismatch("tx_byte", rsp_if.tx_byte, want.tx_byte);
            if (rsp_if.tx_valid !== want.tx_valid)
               report_mismatch("tx_valid", rsp_if.tx_valid, want.tx_valid);
            if (rsp_if.ack_seen !== want.ack_seen)
               report_mismatch("ack_seen", rsp_if.ack_seen, want.ack_seen);
            if (rsp_if.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", rsp_if.last_of_run, want.last_of_run);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_LOCAL_ADDR;
      csr_wdata         <= 8'h00;
      req_if.valid      <= 1'b0;
      req_if.action     <= ACT_SEND;
      req_if.data_byte  <= 8'h00;
      req_if.first_byte <= 1'b0;
      req_if.last_byte  <= 1'b0;
      req_if.seq_bit    <= 1'b0;
      cfg_local    = LOCAL_ADDR_RESET;
      cfg_peer     = PEER_ADDR_RESET;
      cfg_ack_base = ACK_BASE_RESET;
      check_acc    = 8'h00;
      frame_seq    = 1'b0;
      rx_state     = RX_IDLE;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_frames();
      test_directed_ack_recognizer();
      test_unstuffed_header();
      test_random_traffic();
      test_backpressure();
      wait_idle();

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
